>>> hw/rtl/gsp_pkg.sv
// Shared types, constants and helpers of the 8-way grid shortest path block.
package gsp_pkg;

    localparam int MAX_ROWS_DEF   = 128;
    localparam int MAX_COLS_DEF   = 128;
    localparam int HEAP_DEPTH_DEF = 131072;

    localparam int DIST_W = 25;
    localparam int DIM_W  = 11;   // holds any active dimension up to 1024
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [DIST_W-1:0] DIST_TOP      = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] COST_STRAIGHT = DIST_W'(1000);
    localparam logic [DIST_W-1:0] COST_DIAGONAL = DIST_W'(1414);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA = 2'd2;

    localparam logic [7:0] CODE_STAR   = 8'h2A;
    localparam logic [7:0] CODE_AT     = 8'h40;
    localparam logic [7:0] EXTRA_RESET = 8'd42;
    localparam logic [7:0] DIM_RESET   = 8'd128;

    localparam logic [1:0] DIR_DEC  = 2'd0;
    localparam logic [1:0] DIR_HOLD = 2'd1;
    localparam logic [1:0] DIR_INC  = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [6:0] row;
        logic [6:0] col;
        logic [7:0] cell_code;
        logic [6:0] end_row;
        logic [6:0] end_col;
    } in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_milli;
        logic              reached;
        logic              pred_valid;
        logic [6:0]        pred_row;
        logic [6:0]        pred_col;
    } out_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LATCH, OP_LOAD, OP_PRED_RD, OP_PRED_TAKE, OP_CLEAR, OP_START,
        OP_POP_RD, OP_POP_TOP, OP_POP_LAST, OP_SD_RDL, OP_SD_CMPL, OP_SD_CMPR,
        OP_SD_MOVE, OP_SD_PLACE, OP_U_RD, OP_U_TAKE, OP_NB_CALC, OP_NB_CHECK,
        OP_PU_INIT, OP_PU_RD, OP_PU_CMP, OP_PU_PLACE, OP_NB_INC, OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       sweep_last;
        logic       start_ok;
        logic       heap_empty;
        logic       heap_full;
        logic       sd_has_l;
        logic       sd_has_r;
        logic       sd_stay;
        logic       u_is_end;
        logic       nb_in;
        logic       relax;
        logic       pu_root;
        logic       pu_up;
        logic       k_last;
    } status_t;

    // neighbour order: row-major over the 3x3 window, center skipped
    function automatic logic [1:0] nb_dr(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0, 3'd1, 3'd2: d = DIR_DEC;
            3'd3, 3'd4:       d = DIR_HOLD;
            default:          d = DIR_INC;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] nb_dc(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0, 3'd3, 3'd5: d = DIR_DEC;
            3'd1, 3'd6:       d = DIR_HOLD;
            default:          d = DIR_INC;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/grid_shortest_path_8way.sv
// Top level: 8-way grid Dijkstra search with cell load and predecessor read.
// A load or a predecessor read takes its memory step, then stages the result beat;
//   a query first clears all 2^(row bits + col bits) cells of the distance and
//   predecessor stores, then pops the heap and relaxes each neighbour; the search
//   loop over the heap RAM sets how long a query takes.
// Throughput: one item at a time; a new beat is taken once the result is staged.
// Reset: async active low; a clearing pass over the distance and predecessor stores
//   follows, with in_ready low; config writes still land.
module grid_shortest_path_8way #(
    parameter int MAX_ROWS   = gsp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = gsp_pkg::MAX_COLS_DEF,
    parameter int HEAP_DEPTH = gsp_pkg::HEAP_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  gsp_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output gsp_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    gsp_pkg::cmd_t    cmd;
    gsp_pkg::status_t status;

    // sequencer: one state per memory step of the search
    gsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // datapath: memories, heap compares, neighbour arithmetic, result register
    gsp_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .HEAP_DEPTH(HEAP_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .status   (status)
    );
endmodule

>>> hw/rtl/gsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> hw/rtl/gsp_ctrl.sv
// Sequencer of the path search: handshakes, heap walks, neighbour loop.
module gsp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output gsp_pkg::cmd_t    cmd,
    input  gsp_pkg::status_t status
);
    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DECODE, S_LOAD, S_RD0, S_RD1, S_CLEAR, S_START,
        S_POP0, S_POP1, S_POP2, S_SD_L, S_SD_LC, S_SD_RC, S_SD_MV, S_SD_END,
        S_U0, S_U1, S_NB0, S_NB1, S_PU0, S_PU1, S_PU2, S_PU_END, S_NB_NEXT, S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = gsp_pkg::OP_NOP;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_INIT:
            begin
                cmd.op = gsp_pkg::OP_CLEAR;
                if (status.sweep_last) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = gsp_pkg::OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.req_type)
                    gsp_pkg::REQ_LOAD:  state_next = S_LOAD;
                    gsp_pkg::REQ_QUERY: state_next = S_CLEAR;
                    gsp_pkg::REQ_READ:  state_next = S_RD0;
                    default:            state_next = S_FIN;
                endcase
            end
            S_LOAD:
            begin
                cmd.op     = gsp_pkg::OP_LOAD;
                state_next = S_FIN;
            end
            S_RD0:
            begin
                cmd.op     = gsp_pkg::OP_PRED_RD;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.op     = gsp_pkg::OP_PRED_TAKE;
                state_next = S_FIN;
            end
            S_CLEAR:
            begin
                cmd.op = gsp_pkg::OP_CLEAR;
                if (status.sweep_last) state_next = S_START;
            end
            S_START:
            begin
                cmd.op     = gsp_pkg::OP_START;
                state_next = status.start_ok ? S_POP0 : S_FIN;
            end
            S_POP0:
            begin
                if (status.heap_empty)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = gsp_pkg::OP_POP_RD;
                    state_next = S_POP1;
                end
            end
            S_POP1:
            begin
                cmd.op     = gsp_pkg::OP_POP_TOP;
                state_next = S_POP2;
            end
            S_POP2:
            begin
                cmd.op     = gsp_pkg::OP_POP_LAST;
                state_next = status.heap_empty ? S_U0 : S_SD_L;
            end
            S_SD_L:
            begin
                if (status.sd_has_l)
                begin
                    cmd.op     = gsp_pkg::OP_SD_RDL;
                    state_next = S_SD_LC;
                end
                else
                begin
                    state_next = S_SD_END;
                end
            end
            S_SD_LC:
            begin
                cmd.op     = gsp_pkg::OP_SD_CMPL;
                state_next = status.sd_has_r ? S_SD_RC : S_SD_MV;
            end
            S_SD_RC:
            begin
                cmd.op     = gsp_pkg::OP_SD_CMPR;
                state_next = S_SD_MV;
            end
            S_SD_MV:
            begin
                if (status.sd_stay)
                begin
                    state_next = S_SD_END;
                end
                else
                begin
                    cmd.op     = gsp_pkg::OP_SD_MOVE;
                    state_next = S_SD_L;
                end
            end
            S_SD_END:
            begin
                cmd.op     = gsp_pkg::OP_SD_PLACE;
                state_next = S_U0;
            end
            S_U0:
            begin
                cmd.op     = gsp_pkg::OP_U_RD;
                state_next = S_U1;
            end
            S_U1:
            begin
                cmd.op     = gsp_pkg::OP_U_TAKE;
                state_next = status.u_is_end ? S_FIN : S_NB0;
            end
            S_NB0:
            begin
                cmd.op     = gsp_pkg::OP_NB_CALC;
                state_next = status.nb_in ? S_NB1 : S_NB_NEXT;
            end
            S_NB1:
            begin
                cmd.op     = gsp_pkg::OP_NB_CHECK;
                state_next = status.relax ? S_PU0 : S_NB_NEXT;
            end
            S_PU0:
            begin
                if (status.heap_full)
                begin
                    state_next = S_NB_NEXT;
                end
                else
                begin
                    cmd.op     = gsp_pkg::OP_PU_INIT;
                    state_next = S_PU1;
                end
            end
            S_PU1:
            begin
                if (status.pu_root)
                begin
                    state_next = S_PU_END;
                end
                else
                begin
                    cmd.op     = gsp_pkg::OP_PU_RD;
                    state_next = S_PU2;
                end
            end
            S_PU2:
            begin
                cmd.op     = gsp_pkg::OP_PU_CMP;
                state_next = status.pu_up ? S_PU1 : S_PU_END;
            end
            S_PU_END:
            begin
                cmd.op     = gsp_pkg::OP_PU_PLACE;
                state_next = S_NB_NEXT;
            end
            S_NB_NEXT:
            begin
                cmd.op     = gsp_pkg::OP_NB_INC;
                state_next = status.k_last ? S_POP0 : S_NB0;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = gsp_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

>>> hw/rtl/gsp_dp.sv
// Datapath: config registers, grid/distance/predecessor/heap memories, compares.
module gsp_dp #(
    parameter int MAX_ROWS   = gsp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = gsp_pkg::MAX_COLS_DEF,
    parameter int HEAP_DEPTH = gsp_pkg::HEAP_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gsp_pkg::in_t                     in_data,
    output gsp_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  gsp_pkg::cmd_t                    cmd,
    output gsp_pkg::status_t                 status
);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int CELL_W  = ROW_W + COL_W;
    localparam int CELLS   = 1 << CELL_W;
    localparam int HEAP_AW = $clog2(HEAP_DEPTH);
    localparam int DW      = gsp_pkg::DIST_W;
    localparam int DIM_W   = gsp_pkg::DIM_W;
    localparam int HE_W    = DW + CELL_W;
    localparam int PRED_W  = CELL_W + 1;

    gsp_pkg::in_t  req_reg;
    gsp_pkg::out_t res_reg, out_reg;
    logic [7:0]         rows_cfg_reg, cols_cfg_reg, extra_reg;
    logic [CELL_W-1:0]  sweep_reg, u_reg, v_reg;
    logic [HEAP_AW:0]   hcount_reg;
    logic [DW-1:0]      du_reg, nd_reg;
    logic [2:0]         k_reg;
    logic [HEAP_AW-1:0] hi_reg, m_reg;
    logic [HE_W-1:0]    item_reg, best_reg;

    logic               grid_we, dist_we, pred_we, heap_we;
    logic [CELL_W-1:0]  grid_wa, grid_ra, dist_wa, dist_ra, pred_wa, pred_ra;
    logic [7:0]         grid_wd, grid_rd;
    logic [DW-1:0]      dist_wd, dist_rd;
    logic [PRED_W-1:0]  pred_wd, pred_rd;
    logic [HEAP_AW-1:0] heap_wa, heap_ra;
    logic [HE_W-1:0]    heap_wd, heap_rd;

    logic [DIM_W-1:0]   rows_act, cols_act;
    logic               store_ok, start_ok, nr_ok, nc_ok, passable;
    logic [CELL_W-1:0]  req_cell, v_c;
    logic [ROW_W-1:0]   ur, nr;
    logic [COL_W-1:0]   uc, nc;
    logic [DW-1:0]      w_c, nd_c;
    logic [DW:0]        sum_c;
    logic [HEAP_AW+1:0] l_w, r_w, cnt_w;
    logic [HEAP_AW-1:0] parent_c;

    gsp_ram #(.WIDTH(8), .DEPTH(CELLS)) u_grid (
        .clk(clk), .we(grid_we), .waddr(grid_wa), .wdata(grid_wd),
        .raddr(grid_ra), .rdata(grid_rd));
    gsp_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
        .raddr(dist_ra), .rdata(dist_rd));
    gsp_ram #(.WIDTH(PRED_W), .DEPTH(CELLS)) u_pred (
        .clk(clk), .we(pred_we), .waddr(pred_wa), .wdata(pred_wd),
        .raddr(pred_ra), .rdata(pred_rd));
    gsp_ram #(.WIDTH(HE_W), .DEPTH(1 << HEAP_AW)) u_heap (
        .clk(clk), .we(heap_we), .waddr(heap_wa), .wdata(heap_wd),
        .raddr(heap_ra), .rdata(heap_rd));

    // active dimensions: 0 acts as 1, clamp at the store size
    always_comb
    begin
        if (rows_cfg_reg == 8'd0) rows_act = DIM_W'(1);
        else if (DIM_W'(rows_cfg_reg) > DIM_W'(MAX_ROWS)) rows_act = DIM_W'(MAX_ROWS);
        else rows_act = DIM_W'(rows_cfg_reg);
        if (cols_cfg_reg == 8'd0) cols_act = DIM_W'(1);
        else if (DIM_W'(cols_cfg_reg) > DIM_W'(MAX_COLS)) cols_act = DIM_W'(MAX_COLS);
        else cols_act = DIM_W'(cols_cfg_reg);
    end

    assign req_cell = {ROW_W'(req_reg.row), COL_W'(req_reg.col)};
    assign store_ok = (DIM_W'(req_reg.row) < DIM_W'(MAX_ROWS))
                   && (DIM_W'(req_reg.col) < DIM_W'(MAX_COLS));
    assign start_ok = (DIM_W'(req_reg.row) < rows_act) && (DIM_W'(req_reg.col) < cols_act);

    assign ur = u_reg[CELL_W-1:COL_W];
    assign uc = u_reg[COL_W-1:0];

    always_comb
    begin
        case (gsp_pkg::nb_dr(k_reg))
            gsp_pkg::DIR_DEC:  begin nr_ok = (ur != '0); nr = ur - 1'b1; end
            gsp_pkg::DIR_HOLD: begin nr_ok = 1'b1; nr = ur; end
            gsp_pkg::DIR_INC:  begin nr_ok = (DIM_W'(ur) + 1'b1) < rows_act; nr = ur + 1'b1; end
            default:           begin nr_ok = 1'b0; nr = ur; end
        endcase
        case (gsp_pkg::nb_dc(k_reg))
            gsp_pkg::DIR_DEC:  begin nc_ok = (uc != '0); nc = uc - 1'b1; end
            gsp_pkg::DIR_HOLD: begin nc_ok = 1'b1; nc = uc; end
            gsp_pkg::DIR_INC:  begin nc_ok = (DIM_W'(uc) + 1'b1) < cols_act; nc = uc + 1'b1; end
            default:           begin nc_ok = 1'b0; nc = uc; end
        endcase
    end

    assign v_c   = {nr, nc};
    assign w_c   = (gsp_pkg::nb_dr(k_reg) != gsp_pkg::DIR_HOLD
                 && gsp_pkg::nb_dc(k_reg) != gsp_pkg::DIR_HOLD)
                 ? gsp_pkg::COST_DIAGONAL : gsp_pkg::COST_STRAIGHT;
    assign sum_c = {1'b0, du_reg} + {1'b0, w_c};
    assign nd_c  = sum_c[DW] ? gsp_pkg::DIST_TOP : sum_c[DW-1:0];

    assign passable = (grid_rd != 8'd0) && (grid_rd == gsp_pkg::CODE_STAR
                   || grid_rd == gsp_pkg::CODE_AT || grid_rd == extra_reg);

    // heap entries compare as {dist, cell}: lower is popped first
    assign l_w      = {1'b0, hi_reg, 1'b1};
    assign r_w      = l_w + 1'b1;
    assign cnt_w    = {1'b0, hcount_reg};
    assign parent_c = (hi_reg - 1'b1) >> 1;

    always_comb
    begin
        status.req_type   = req_reg.req_type;
        status.sweep_last = &sweep_reg;
        status.start_ok   = start_ok;
        status.heap_empty = (hcount_reg == '0);
        status.heap_full  = (hcount_reg >= (HEAP_AW+1)'(HEAP_DEPTH));
        status.sd_has_l   = l_w < cnt_w;
        status.sd_has_r   = r_w < cnt_w;
        status.sd_stay    = (m_reg == hi_reg);
        status.u_is_end   = (DIM_W'(ur) == DIM_W'(req_reg.end_row))
                         && (DIM_W'(uc) == DIM_W'(req_reg.end_col));
        status.nb_in      = nr_ok && nc_ok;
        status.relax      = passable && (nd_reg < dist_rd);
        status.pu_root    = (hi_reg == '0);
        status.pu_up      = item_reg < heap_rd;
        status.k_last     = (k_reg == 3'd7);
    end

    // memory port steering
    always_comb
    begin
        grid_we = 1'b0; grid_wa = req_cell; grid_wd = req_reg.cell_code; grid_ra = v_c;
        dist_we = 1'b0; dist_wa = v_reg;    dist_wd = nd_reg;            dist_ra = v_c;
        pred_we = 1'b0; pred_wa = v_reg;    pred_wd = {1'b1, u_reg};     pred_ra = req_cell;
        heap_we = 1'b0; heap_wa = hi_reg;   heap_wd = item_reg;          heap_ra = '0;
        case (cmd.op)
            gsp_pkg::OP_LOAD: grid_we = store_ok;
            gsp_pkg::OP_CLEAR:
            begin
                dist_we = 1'b1; dist_wa = sweep_reg; dist_wd = gsp_pkg::DIST_TOP;
                pred_we = 1'b1; pred_wa = sweep_reg; pred_wd = '0;
            end
            gsp_pkg::OP_START:
            begin
                dist_we = start_ok; dist_wa = req_cell; dist_wd = '0;
                heap_we = start_ok; heap_wa = '0; heap_wd = {{DW{1'b0}}, req_cell};
            end
            gsp_pkg::OP_POP_TOP:  heap_ra = HEAP_AW'(hcount_reg - 1'b1);
            gsp_pkg::OP_SD_RDL:   heap_ra = l_w[HEAP_AW-1:0];
            gsp_pkg::OP_SD_CMPL:  heap_ra = r_w[HEAP_AW-1:0];
            gsp_pkg::OP_SD_MOVE:  begin heap_we = 1'b1; heap_wd = best_reg; end
            gsp_pkg::OP_SD_PLACE: heap_we = 1'b1;
            gsp_pkg::OP_U_RD:     dist_ra = u_reg;
            gsp_pkg::OP_NB_CHECK:
            begin
                dist_we = status.relax;
                pred_we = status.relax;
            end
            gsp_pkg::OP_PU_RD:    heap_ra = parent_c;
            gsp_pkg::OP_PU_CMP:   begin heap_we = status.pu_up; heap_wd = heap_rd; end
            gsp_pkg::OP_PU_PLACE: heap_we = 1'b1;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= gsp_pkg::DIM_RESET;
            cols_cfg_reg <= gsp_pkg::DIM_RESET;
            extra_reg    <= gsp_pkg::EXTRA_RESET;
            sweep_reg    <= '0;
            hcount_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    gsp_pkg::CFG_ROWS:  rows_cfg_reg <= cfg_data;
                    gsp_pkg::CFG_COLS:  cols_cfg_reg <= cfg_data;
                    gsp_pkg::CFG_EXTRA: extra_reg    <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                gsp_pkg::OP_CLEAR:   sweep_reg  <= sweep_reg + 1'b1;
                gsp_pkg::OP_START:   hcount_reg <= start_ok ? (HEAP_AW+1)'(1) : '0;
                gsp_pkg::OP_POP_TOP: hcount_reg <= hcount_reg - 1'b1;
                gsp_pkg::OP_PU_INIT: hcount_reg <= hcount_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            gsp_pkg::OP_LATCH:
            begin
                req_reg <= in_data;
                res_reg <= '0;
            end
            gsp_pkg::OP_PRED_TAKE:
            begin
                if (store_ok && pred_rd[PRED_W-1])
                begin
                    res_reg.pred_valid <= 1'b1;
                    res_reg.pred_row   <= 7'(pred_rd[CELL_W-1:COL_W]);
                    res_reg.pred_col   <= 7'(pred_rd[COL_W-1:0]);
                end
            end
            gsp_pkg::OP_POP_TOP:  u_reg <= heap_rd[CELL_W-1:0];
            gsp_pkg::OP_POP_LAST:
            begin
                item_reg <= heap_rd;
                hi_reg   <= '0;
            end
            gsp_pkg::OP_SD_RDL:
            begin
                best_reg <= item_reg;
                m_reg    <= hi_reg;
            end
            gsp_pkg::OP_SD_CMPL:
            begin
                if (heap_rd < best_reg)
                begin
                    best_reg <= heap_rd;
                    m_reg    <= l_w[HEAP_AW-1:0];
                end
            end
            gsp_pkg::OP_SD_CMPR:
            begin
                if (heap_rd < best_reg)
                begin
                    best_reg <= heap_rd;
                    m_reg    <= r_w[HEAP_AW-1:0];
                end
            end
            gsp_pkg::OP_SD_MOVE:  hi_reg <= m_reg;
            gsp_pkg::OP_U_TAKE:
            begin
                du_reg <= dist_rd;
                k_reg  <= 3'd0;
                if (status.u_is_end)
                begin
                    res_reg.distance_milli <= dist_rd;
                    res_reg.reached        <= 1'b1;
                end
            end
            gsp_pkg::OP_NB_CALC:
            begin
                v_reg  <= v_c;
                nd_reg <= nd_c;
            end
            gsp_pkg::OP_PU_INIT:
            begin
                item_reg <= {nd_reg, v_reg};
                hi_reg   <= hcount_reg[HEAP_AW-1:0];
            end
            gsp_pkg::OP_PU_RD:    m_reg <= parent_c;
            gsp_pkg::OP_PU_CMP:   if (status.pu_up) hi_reg <= m_reg;
            gsp_pkg::OP_NB_INC:   k_reg <= k_reg + 1'b1;
            gsp_pkg::OP_EMIT:     out_reg <= res_reg;
            default: ;
        endcase
    end

    assign out_data = out_reg;
endmodule

>>> hw/rtl/gsp_checker.sv
// Port-level checks of the path search block, bound to the top level.
module gsp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input gsp_pkg::out_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new beat taken while item in flight");

    a_reach_no_pred: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reached |-> !out_data.pred_valid)
        else $error("query result carries predecessor");

    a_unreached_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.reached |-> out_data.distance_milli == '0)
        else $error("distance without reach");
endmodule

bind grid_shortest_path_8way gsp_checker u_gsp_checker (.*);

>>> tb/grid_shortest_path_8way_tb.sv
// Testbench for grid_shortest_path_8way: random and directed grid loads, path queries and reads.
module grid_shortest_path_8way_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCELL       = 128 * 128;
    localparam int DW          = gsp_pkg::DIST_W;
    localparam int STALL_LIMIT = 1000000;   // cycles with no beat on either side
    localparam logic [7:0] CODE_DOT   = 8'h2E;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // frontier entry of the search
    typedef struct {
        int unsigned cost;
        int          node;
    } node_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid = 1'b0;
    logic          in_ready;
    gsp_pkg::in_t  in_data  = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    gsp_pkg::out_t out_data;
    logic          cfg_we;
    logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gsp_pkg::CFG_DATA_W-1:0] cfg_data;

    grid_shortest_path_8way dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register shadow; only changed while the block is idle, so the
    // stimulus side and the predictor can share it
    logic [7:0] rows_reg  = gsp_pkg::DIM_RESET;
    logic [7:0] cols_reg  = gsp_pkg::DIM_RESET;
    logic [7:0] extra_reg = gsp_pkg::EXTRA_RESET;

    // predictor copy of the block state
    logic [7:0]  terrain   [NCELL] = '{default: 8'd0};
    int unsigned best_d    [NCELL] = '{default: 32'(gsp_pkg::DIST_TOP)};
    int          came_from [NCELL] = '{default: -1};    // -1: no predecessor

    gsp_pkg::in_t  pending_q[$];
    gsp_pkg::out_t path_result_q[$];

    int in_sent = 0, in_acc = 0, out_acc = 0, out_seen = 0;
    int gap = 0, stall = 0, hold_left = 0, idle_max = 6;
    bit hold_done = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;

    function automatic int active_dim(logic [7:0] v);
        if (v == 8'd0) return 1;
        if (v > 8'd128) return 128;
        return int'(v);
    endfunction

    function automatic bit can_enter(int node);
        logic [7:0] c;
        c = terrain[node];
        return c != 8'd0 && (c == gsp_pkg::CODE_STAR || c == gsp_pkg::CODE_AT || c == extra_reg);
    endfunction

    // lazy Dijkstra, frontier popped by (distance, cell index)
    task automatic search_path(input int sr, input int sc, input int er, input int ec,
                               output gsp_pkg::out_t res);
        node_t       frontier[$];
        node_t       e;
        int          nrows, ncols, m, u, ur, uc, nr, nc, v;
        int unsigned nd, w;
        res   = '0;
        nrows = active_dim(rows_reg);
        ncols = active_dim(cols_reg);
        for (int i = 0; i < NCELL; i++)
        begin
            best_d[i]    = 32'(gsp_pkg::DIST_TOP);
            came_from[i] = -1;
        end
        if (sr >= nrows || sc >= ncols)
            return;
        u = sr * 128 + sc;
        best_d[u] = 0;
        frontier.insert(frontier.size(), '{0, u});
        while (frontier.size() > 0)
        begin
            m = 0;
            for (int i = 1; i < frontier.size(); i++)
                if (frontier[i].cost < frontier[m].cost ||
                    (frontier[i].cost == frontier[m].cost && frontier[i].node < frontier[m].node))
                    m = i;
            e = frontier[m];
            frontier.delete(m);
            u  = e.node;
            ur = u / 128;
            uc = u % 128;
            if (ur == er && uc == ec)
            begin
                res.distance_milli = DW'(best_d[u]);
                res.reached        = 1'b1;
                return;
            end
            for (int dr = -1; dr <= 1; dr++)
                for (int dc = -1; dc <= 1; dc++)
                begin
                    nr = ur + dr;
                    nc = uc + dc;
                    if (dr == 0 && dc == 0) continue;
                    if (nr < 0 || nc < 0 || nr >= nrows || nc >= ncols) continue;
                    v = nr * 128 + nc;
                    if (!can_enter(v)) continue;
                    w  = (dr != 0 && dc != 0) ? 32'(gsp_pkg::COST_DIAGONAL)
                                              : 32'(gsp_pkg::COST_STRAIGHT);
                    nd = best_d[u] + w;
                    if (nd > 32'(gsp_pkg::DIST_TOP)) nd = 32'(gsp_pkg::DIST_TOP);
                    if (nd < best_d[v])
                    begin
                        best_d[v]    = nd;
                        came_from[v] = u;
                        frontier.insert(frontier.size(), '{nd, v});
                    end
                end
        end
    endtask

    task automatic predict_beat(input gsp_pkg::in_t it);
        gsp_pkg::out_t res;
        int            idx;
        res = '0;
        idx = int'(it.row) * 128 + int'(it.col);
        case (it.req_type)
            gsp_pkg::REQ_LOAD:  terrain[idx] = it.cell_code;
            gsp_pkg::REQ_QUERY: search_path(int'(it.row), int'(it.col), int'(it.end_row),
                                            int'(it.end_col), res);
            gsp_pkg::REQ_READ:
                if (came_from[idx] >= 0)
                begin
                    res.pred_valid = 1'b1;
                    res.pred_row   = 7'(came_from[idx] / 128);
                    res.pred_col   = 7'(came_from[idx] % 128);
                end
            default: ;   // unused request type: all-zero result
        endcase
        path_result_q.insert(path_result_q.size(), res);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d (result beat %0d)",
                 what, got, want, out_acc);
        errors++;
    endtask

    // ---------------- stimulus helpers ----------------
    task automatic add_item(input logic [1:0] t, input int r, input int c,
                            input int code, input int er, input int ec);
        gsp_pkg::in_t it;
        it.req_type  = t;
        it.row       = 7'(r);
        it.col       = 7'(c);
        it.cell_code = 8'(code);
        it.end_row   = 7'(er);
        it.end_col   = 7'(ec);
        pending_q.insert(pending_q.size(), it);
    endtask

    // mostly passable terrain, some walls and odd codes
    function automatic int pick_code();
        case ($urandom_range(0, 9))
            0, 1, 2: return int'(gsp_pkg::CODE_STAR);
            3, 4:    return int'(gsp_pkg::CODE_AT);
            5, 6:    return int'(extra_reg);
            7:       return 0;
            default: return int'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic fill_rect(input int r0, input int r1, input int c0, input int c1);
        for (int r = r0; r <= r1; r++)
            for (int c = c0; c <= c1; c++)
                add_item(gsp_pkg::REQ_LOAD, r, c, pick_code(), int'($urandom_range(0, 127)),
                         int'($urandom_range(0, 127)));
    endtask

    task automatic fill_region();
        fill_rect(0, active_dim(rows_reg) - 1, 0, active_dim(cols_reg) - 1);
    endtask

    // wait for every beat to drain, then a few cycles of margin
    task automatic wait_idle();
        while (pending_q.size() != 0 || in_valid || path_result_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gsp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            gsp_pkg::CFG_ROWS:  rows_reg  = val;
            gsp_pkg::CFG_COLS:  cols_reg  = val;
            gsp_pkg::CFG_EXTRA: extra_reg = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_items(input int n);
        int nr, nc;
        nr = active_dim(rows_reg);
        nc = active_dim(cols_reg);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    add_item(gsp_pkg::REQ_LOAD, $urandom_range(0, nr - 1),
                             $urandom_range(0, nc - 1), pick_code(),
                             $urandom_range(0, 127), $urandom_range(0, 127));
                2:  // anywhere in the store, kept outside the searched window
                    add_item(gsp_pkg::REQ_LOAD, $urandom_range(nr, 127), $urandom_range(0, 127),
                             $urandom_range(0, 255), $urandom_range(0, 127),
                             $urandom_range(0, 127));
                3, 4, 5:
                    add_item(gsp_pkg::REQ_QUERY, $urandom_range(0, nr - 1),
                             $urandom_range(0, nc - 1), $urandom_range(0, 255),
                             $urandom_range(0, nr - 1), $urandom_range(0, nc - 1));
                6:  // start or end possibly out of the window
                    add_item(gsp_pkg::REQ_QUERY, $urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(0, 255), $urandom_range(0, 127),
                             $urandom_range(0, 127));
                7, 8:
                    add_item(gsp_pkg::REQ_READ, int'($urandom_range(0, 127)) % (nr + 1),
                             $urandom_range(0, 127), $urandom_range(0, 255),
                             $urandom_range(0, 127), $urandom_range(0, 127));
                default:
                    add_item(REQ_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(0, 255), $urandom_range(0, 127),
                             $urandom_range(0, 127));
            endcase
        end
    endtask

    // ---------------- clock and reset ----------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------- sender: one beat per pending item ----------------
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_acc == in_sent))
        begin
            if (gap > 0)
            begin
                gap      <= gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                in_data  <= pending_q.pop_front();
                in_valid <= 1'b1;
                in_sent  <= in_sent + 1;
                gap      <= $urandom_range(0, idle_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- receiver: random stalls plus one long hold ----------------
    always @(negedge clk)
    begin
        if (out_acc != out_seen)
        begin
            out_seen = out_acc;
            stall    = $urandom_range(0, idle_max);
        end
        // once, after the thirtieth result beat, stop draining so in_ready backs up
        if (!hold_done && out_acc == 30)
        begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall > 0)
        begin
            stall--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ---------------- monitor: predict on input beats, check output beats ----------------
    always @(posedge clk)
    begin
        gsp_pkg::out_t want;
        if (in_valid && in_ready)
        begin
            predict_beat(in_data);
            in_acc <= in_acc + 1;
        end
        if (out_valid && out_ready)
        begin
            out_acc <= out_acc + 1;
            if (path_result_q.size() == 0)
            begin
                report("unexpected result beat", 1, 0);
            end
            else
            begin
                want = path_result_q.pop_front();
                if (out_data.distance_milli !== want.distance_milli)
                    report("distance_milli", longint'(out_data.distance_milli),
                           longint'(want.distance_milli));
                if (out_data.reached !== want.reached)
                    report("reached", longint'(out_data.reached), longint'(want.reached));
                if (out_data.pred_valid !== want.pred_valid)
                    report("pred_valid", longint'(out_data.pred_valid),
                           longint'(want.pred_valid));
                if (out_data.pred_row !== want.pred_row)
                    report("pred_row", longint'(out_data.pred_row), longint'(want.pred_row));
                if (out_data.pred_col !== want.pred_col)
                    report("pred_col", longint'(out_data.pred_col), longint'(want.pred_col));
            end
        end
    end

    // watchdog: a long query is fine, a dead handshake is not
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- test sequence ----------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 3x3 window
        //   *  @  42
        //   0  .  *
        //   @ FF  *
        // bottom-left pocket is walled off from the top-left corner
        write_reg(gsp_pkg::CFG_ROWS, 8'd3);
        write_reg(gsp_pkg::CFG_COLS, 8'd3);
        write_reg(gsp_pkg::CFG_EXTRA, 8'd42);
        add_item(gsp_pkg::REQ_LOAD, 0, 0, int'(gsp_pkg::CODE_STAR), 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 0, 1, int'(gsp_pkg::CODE_AT), 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 0, 2, 42, 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 1, 0, 0, 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 1, 1, int'(CODE_DOT), 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 1, 2, int'(gsp_pkg::CODE_STAR), 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 2, 0, int'(gsp_pkg::CODE_AT), 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 2, 1, 255, 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 2, 2, int'(gsp_pkg::CODE_STAR), 0, 0);
        add_item(gsp_pkg::REQ_LOAD, 127, 127, 255, 127, 127);   // far corner of the store
        add_item(gsp_pkg::REQ_QUERY, 0, 0, 0, 2, 2);            // straight plus diagonal steps
        add_item(gsp_pkg::REQ_READ, 2, 2, 0, 0, 0);
        add_item(gsp_pkg::REQ_READ, 1, 2, 0, 0, 0);
        add_item(gsp_pkg::REQ_READ, 0, 0, 0, 0, 0);             // start has no predecessor
        add_item(gsp_pkg::REQ_READ, 127, 127, 0, 0, 0);
        add_item(gsp_pkg::REQ_QUERY, 0, 0, 0, 0, 0);            // start equals end
        add_item(gsp_pkg::REQ_QUERY, 0, 0, 0, 2, 0);            // unreachable end
        add_item(gsp_pkg::REQ_QUERY, 2, 0, 0, 0, 0);            // start in the walled pocket
        add_item(gsp_pkg::REQ_QUERY, 0, 0, 0, 127, 127);        // end outside the window
        add_item(gsp_pkg::REQ_QUERY, 5, 1, 0, 0, 0);            // start outside: stores cleared
        add_item(gsp_pkg::REQ_READ, 2, 2, 0, 0, 0);
        add_item(REQ_UNUSED, 127, 127, 255, 127, 127);          // unused request type
        wait_idle();

        // one row of 128 columns, extra code 0 (code 0 must stay a wall);
        // only the far end of the row is loaded and searched
        idle_max = 0;
        write_reg(gsp_pkg::CFG_ROWS, 8'd0);
        write_reg(gsp_pkg::CFG_COLS, 8'd255);
        write_reg(gsp_pkg::CFG_EXTRA, 8'd0);
        fill_rect(0, 0, 120, 127);
        add_item(gsp_pkg::REQ_QUERY, 0, 127, 0, 0, 120);
        add_item(gsp_pkg::REQ_READ, 0, 120, 0, 0, 0);
        add_item(gsp_pkg::REQ_READ, 0, 126, 0, 0, 0);
        add_item(gsp_pkg::REQ_QUERY, 0, 127, 0, 0, 127);        // last column, start equals end
        add_item(gsp_pkg::REQ_QUERY, 1, 3, 0, 0, 0);            // row past the single row
        wait_idle();

        // one column of 128 rows, bottom end only
        idle_max = 6;
        write_reg(gsp_pkg::CFG_ROWS, 8'd255);
        write_reg(gsp_pkg::CFG_COLS, 8'd0);
        write_reg(gsp_pkg::CFG_EXTRA, 8'd255);
        fill_rect(120, 127, 0, 0);
        add_item(gsp_pkg::REQ_QUERY, 127, 0, 0, 120, 0);
        add_item(gsp_pkg::REQ_READ, 120, 0, 0, 0, 0);
        add_item(gsp_pkg::REQ_QUERY, 127, 0, 0, 127, 0);
        add_item(gsp_pkg::REQ_QUERY, 3, 1, 0, 0, 0);            // column past the single column
        wait_idle();

        // small random windows with busy traffic
        for (int ph = 0; ph < 3; ph++)
        begin
            idle_max = (ph == 1) ? 0 : 6;
            write_reg(gsp_pkg::CFG_ROWS, 8'($urandom_range(1, 4)));
            write_reg(gsp_pkg::CFG_COLS, 8'($urandom_range(1, 4)));
            write_reg(gsp_pkg::CFG_EXTRA, 8'($urandom_range(0, 255)));
            fill_region();
            random_items(12);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> grid_shortest_path_8way.f
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_ram.sv
hw/rtl/gsp_ctrl.sv
hw/rtl/gsp_dp.sv
hw/rtl/grid_shortest_path_8way.sv
hw/rtl/gsp_checker.sv
tb/grid_shortest_path_8way_tb.sv
